FILE: sv/csfw_pkg.sv
// ----------------------------------------------------------------------------
// csfw_pkg
// Shared types, widths and constants for the cubic spline filter warp.
// ----------------------------------------------------------------------------
package csfw_pkg;

  // port widths fixed by the sample formats
  localparam int IN_WIDTH  = 16;
  localparam int OUT_WIDTH = 17;

  // default fraction widths
  localparam int IN_FRAC_BITS_DEF  = 16;
  localparam int OUT_FRAC_BITS_DEF = 14;

  // rational step argument is unsigned Q0.30
  localparam int ARG_BITS = 30;
  localparam int T_W      = ARG_BITS + 1;
  // divide by eleven: floor(p / 11) = (p * RECIP_ELEVEN) >> RECIP_SHIFT
  // holds for every p below 2^28
  localparam int RECIP_W     = 29;
  localparam int RECIP_SHIFT = 32;
  localparam logic [RECIP_W-1:0] RECIP_ELEVEN = 29'd390451573;
  localparam logic [3:0] DIVISOR_ELEVEN = 4'd11;
  localparam int DIV11_STAGES = 2;
  // width of numerator and denominator of the rational step
  localparam int POLY_W = ARG_BITS + 5;
  // polynomial stages between the two dividers
  localparam int POLY_STAGES = 4;

  // which piece of the inverse applies to a coordinate
  typedef enum logic [1:0] {
    CASE_LOW_ROOT,
    CASE_LOW_RATIONAL,
    CASE_HIGH_RATIONAL,
    CASE_HIGH_ROOT
  } csfw_case_e;

  // register stages through one lane
  function automatic int csfw_lane_latency(input int out_frac);
    return DIV11_STAGES + POLY_STAGES + POLY_W + out_frac;
  endfunction

endpackage

FILE: sv/csfw_div_cell.sv
// ----------------------------------------------------------------------------
// csfw_div_cell
// One restoring division step: shifts one dividend bit into the partial
// remainder and one quotient bit into the freed low end of the dividend.
// ----------------------------------------------------------------------------
module csfw_div_cell #(
  parameter int NW = 34,
  parameter int DW = 4
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] rem_i,
  input  logic [DW-1:0] div_i,
  output logic [NW-1:0] num_o,
  output logic [DW-1:0] rem_o,
  output logic [DW-1:0] div_o
);

  logic [DW:0]   trial;
  logic          ge;
  logic [DW-1:0] rem_d, rem_q, div_q;
  logic [NW-1:0] num_d, num_q;

  // trial subtract of the divisor
  always_comb begin
    trial = {rem_i, num_i[NW-1]};
    ge    = (trial >= {1'b0, div_i});
    rem_d = ge ? DW'(trial - {1'b0, div_i}) : trial[DW-1:0];
    num_d = {num_i[NW-2:0], ge};
  end

  // hand over to the next cell
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q <= num_d;
      rem_q <= rem_d;
      div_q <= div_i;
    end
  end

  assign num_o = num_q;
  assign rem_o = rem_q;
  assign div_o = div_q;

endmodule

FILE: sv/csfw_sqrt_cell.sv
// ----------------------------------------------------------------------------
// csfw_sqrt_cell
// One restoring square root step: takes two operand bits and decides one
// root bit.
// ----------------------------------------------------------------------------
module csfw_sqrt_cell #(
  parameter int OPW = 58,
  parameter int RTW = 29
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [OPW-1:0]   op_i,
  input  logic [RTW-1:0]   root_i,
  input  logic [RTW+1:0]   rem_i,
  output logic [OPW-1:0]   op_o,
  output logic [RTW-1:0]   root_o,
  output logic [RTW+1:0]   rem_o
);

  logic [RTW+1:0] rem_sh, trial, rem_d, rem_q;
  logic [RTW-1:0] root_d, root_q;
  logic [OPW-1:0] op_d, op_q;
  logic           ge;

  // bring down two bits and try root*4+1
  always_comb begin
    rem_sh = {rem_i[RTW-1:0], op_i[OPW-1:OPW-2]};
    trial  = {root_i, 2'b01};
    ge     = (rem_sh >= trial);
    rem_d  = ge ? (rem_sh - trial) : rem_sh;
    root_d = {root_i[RTW-2:0], ge};
    op_d   = {op_i[OPW-3:0], 2'b00};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op_q   <= op_d;
      root_q <= root_d;
      rem_q  <= rem_d;
    end
  end

  assign op_o   = op_q;
  assign root_o = root_q;
  assign rem_o  = rem_q;

endmodule

FILE: sv/csfw_lane.sv
// ----------------------------------------------------------------------------
// csfw_lane
// Warps one coordinate: a reciprocal divide by eleven, polynomial stages and
// a chain of divide cells for the rational pieces, two nested chains of square
// root cells for the root pieces, and a final select and clamp.
// ----------------------------------------------------------------------------
module csfw_lane import csfw_pkg::*; #(
  parameter int IN_FRAC_BITS  = IN_FRAC_BITS_DEF,
  parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [IN_WIDTH-1:0]         coord_i,
  output logic signed [OUT_WIDTH-1:0] warped_o
);

  localparam int IFB = IN_FRAC_BITS;
  localparam int OFB = OUT_FRAC_BITS;
  localparam int XW  = IFB + 5;
  localparam int PW  = IFB + 4;
  localparam int MW  = IFB + 1;
  localparam int LAT = csfw_lane_latency(OFB);
  // divide by eleven
  localparam int SH  = ARG_BITS - IFB;
  localparam int RPW = PW + RECIP_W;
  localparam int QW  = RPW - RECIP_SHIFT;
  // root chains
  localparam int OP1 = 4 * OFB + 2;
  localparam int RT1 = 2 * OFB + 1;
  localparam int OP2 = 2 * OFB + 2;
  localparam int RT2 = OFB + 1;
  localparam int ROOT_LAT = RT1 + RT2;
  localparam int PAD = LAT - ROOT_LAT;
  // final divider
  localparam int FNW = POLY_W + OFB;
  localparam int UW  = OFB + 3;
  localparam int VW  = (OFB + 5 > OUT_WIDTH) ? OFB + 5 : OUT_WIDTH;

  localparam logic [XW-1:0] S_X   = XW'(1) << IFB;
  localparam logic [XW-1:0] S23_X = XW'(23) << IFB;
  localparam logic [XW-1:0] S24_X = XW'(24) << IFB;
  localparam logic signed [VW-1:0] ONE_U = VW'(1) << OFB;
  localparam logic signed [VW-1:0] TWO_U = VW'(2) << OFB;

  logic [IFB-1:0] x_sat;
  logic [XW-1:0]  x24;
  csfw_case_e     case_d;
  logic [PW-1:0]  p_arg;
  logic [MW-1:0]  m_arg;

  // saturate coordinates at or above one
  generate
    if (IFB < IN_WIDTH) begin : g_sat
      always_comb begin
        if (coord_i >= IN_WIDTH'(S_X)) x_sat = {IFB{1'b1}};
        else x_sat = coord_i[IFB-1:0];
      end
    end else begin : g_nosat
      assign x_sat = IFB'(coord_i);
    end
  endgenerate

  // pick the piece and form its argument
  always_comb begin
    x24 = XW'({x_sat, 4'b0000}) + XW'({x_sat, 3'b000});
    if (x24 < S_X) case_d = CASE_LOW_ROOT;
    else if (!x_sat[IFB-1]) case_d = CASE_LOW_RATIONAL;
    else if (x24 < S23_X) case_d = CASE_HIGH_RATIONAL;
    else case_d = CASE_HIGH_ROOT;
    p_arg = (case_d == CASE_LOW_RATIONAL) ? PW'(x24 - S_X) : PW'(S23_X - x24);
    m_arg = (case_d == CASE_HIGH_ROOT) ? MW'(S24_X - x24) : MW'(x24);
  end

  // floor(b * 2^SH / 11) for a remainder b of the divide by eleven
  function automatic logic [T_W-1:0] eleventh_frac(input logic [3:0] b);
    logic [T_W-1:0] f;
    f = '0;
    for (int k = 1; k < 11; k++) begin
      if (b == 4'(k)) f = T_W'((64'(k) << SH) / 64'd11);
    end
    return f;
  endfunction

  // divide by eleven: reciprocal product, then the scaled remainder
  logic [RPW-1:0] recip_prod;
  logic [QW-1:0]  quo_q;
  logic [3:0]     p_lo_q;
  logic [3:0]     rem11;
  logic [T_W-1:0] t_q;

  assign recip_prod = RPW'(p_arg) * RPW'(RECIP_ELEVEN);
  assign rem11      = p_lo_q - 4'(quo_q[3:0] * DIVISOR_ELEVEN);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_q  <= recip_prod[RPW-1:RECIP_SHIFT];
      p_lo_q <= p_arg[3:0];
      t_q    <= (T_W'(quo_q) << SH) + eleventh_frac(rem11);
    end
  end

  // powers of the argument, one product per stage
  logic [2*T_W-1:0]   sq, cu, qu;
  logic [T_W-1:0]     t2_q, t2b_q, t22_q, t3_q, t23_q;
  logic [POLY_W-1:0]  num_q, den_q;

  always_comb begin
    sq = t_q * t_q;
    cu = t22_q * t2_q;
    qu = t3_q * t23_q;
  end

  // the polynomial registers; placed below for clarity
  logic [T_W-1:0] s3_t, s3_t2, s3_t3, s3_t4;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // stage one: square
      t2_q  <= t_q;
      t22_q <= sq[ARG_BITS+T_W-1:ARG_BITS];
      // stage two: cube
      t23_q <= t2_q;
      t2b_q <= t22_q;
      t3_q  <= cu[ARG_BITS+T_W-1:ARG_BITS];
      // stage three: fourth power
      s3_t  <= t23_q;
      s3_t2 <= t2b_q;
      s3_t3 <= t3_q;
      s3_t4 <= qu[ARG_BITS+T_W-1:ARG_BITS];
      // stage four: numerator and denominator
      num_q <= POLY_W'(s3_t) * POLY_W'(11) + POLY_W'(s3_t2) * POLY_W'(6)
             + POLY_W'(s3_t3) * POLY_W'(8) - POLY_W'(s3_t4) * POLY_W'(9);
      den_q <= (POLY_W'(4) << ARG_BITS) + POLY_W'(s3_t) * POLY_W'(12)
             + POLY_W'(s3_t2) * POLY_W'(12) - POLY_W'(s3_t3) * POLY_W'(12);
    end
  end

  // final divide num * 2^OFB / den
  logic [FNW-1:0]    fd_num [0:FNW];
  logic [POLY_W-1:0] fd_rem [0:FNW];
  logic [POLY_W-1:0] fd_div [0:FNW];

  assign fd_num[0] = {num_q, {OFB{1'b0}}};
  assign fd_rem[0] = '0;
  assign fd_div[0] = den_q;

  generate
    for (genvar i = 0; i < FNW; i++) begin : g_fd
      csfw_div_cell #(.NW(FNW), .DW(POLY_W)) u_cell (
        .clk_i (clk_i),
        .en_i  (en_i),
        .num_i (fd_num[i]),
        .rem_i (fd_rem[i]),
        .div_i (fd_div[i]),
        .num_o (fd_num[i+1]),
        .rem_o (fd_rem[i+1]),
        .div_o (fd_div[i+1])
      );
    end
  endgenerate

  // fourth root as two nested square roots
  logic [OP1-1:0] r1_op   [0:RT1];
  logic [RT1-1:0] r1_root [0:RT1];
  logic [RT1+1:0] r1_rem  [0:RT1];
  logic [OP2-1:0] r2_op   [0:RT2];
  logic [RT2-1:0] r2_root [0:RT2];
  logic [RT2+1:0] r2_rem  [0:RT2];

  assign r1_op[0]   = {1'b0, m_arg, {(4 * OFB - IFB){1'b0}}};
  assign r1_root[0] = '0;
  assign r1_rem[0]  = '0;

  generate
    for (genvar i = 0; i < RT1; i++) begin : g_r1
      csfw_sqrt_cell #(.OPW(OP1), .RTW(RT1)) u_cell (
        .clk_i  (clk_i),
        .en_i   (en_i),
        .op_i   (r1_op[i]),
        .root_i (r1_root[i]),
        .rem_i  (r1_rem[i]),
        .op_o   (r1_op[i+1]),
        .root_o (r1_root[i+1]),
        .rem_o  (r1_rem[i+1])
      );
    end
  endgenerate

  assign r2_op[0]   = {1'b0, r1_root[RT1]};
  assign r2_root[0] = '0;
  assign r2_rem[0]  = '0;

  generate
    for (genvar i = 0; i < RT2; i++) begin : g_r2
      csfw_sqrt_cell #(.OPW(OP2), .RTW(RT2)) u_cell (
        .clk_i  (clk_i),
        .en_i   (en_i),
        .op_i   (r2_op[i]),
        .root_i (r2_root[i]),
        .rem_i  (r2_rem[i]),
        .op_o   (r2_op[i+1]),
        .root_o (r2_root[i+1]),
        .rem_o  (r2_rem[i+1])
      );
    end
  endgenerate

  // align root result and piece select with the rational path
  logic [RT2-1:0] pad_q  [0:PAD-1];
  csfw_case_e     case_q [0:LAT-1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pad_q[0]  <= r2_root[RT2];
      case_q[0] <= case_d;
      for (int i = 1; i < PAD; i++) pad_q[i] <= pad_q[i-1];
      for (int i = 1; i < LAT; i++) case_q[i] <= case_q[i-1];
    end
  end

  // offset, mirror and clamp
  logic [UW-1:0]          u_val;
  logic signed [VW-1:0]   root_s, u_s, v, v_cl;

  always_comb begin
    u_val  = fd_num[FNW][UW-1:0];
    root_s = $signed(VW'(pad_q[PAD-1]));
    u_s    = $signed(VW'(u_val));
    unique case (case_q[LAT-1])
      CASE_LOW_ROOT:      v = root_s - TWO_U;
      CASE_LOW_RATIONAL:  v = u_s - ONE_U;
      CASE_HIGH_RATIONAL: v = ONE_U - u_s;
      CASE_HIGH_ROOT:     v = TWO_U - root_s;
      default:            v = '0;
    endcase
    if (v > TWO_U) v_cl = TWO_U;
    else if (v < -TWO_U) v_cl = -TWO_U;
    else v_cl = v;
  end

  assign warped_o = v_cl[OUT_WIDTH-1:0];

endmodule

FILE: sv/cubic_spline_filter_warp.sv
// ----------------------------------------------------------------------------
// cubic_spline_filter_warp
// Warps pairs of uniform Q0.16 coordinates through the inverse of the cubic
// spline filter into signed Q2.14, one pair per cycle while stall_o is low.
//
//   channel  signals                                          direction
//   input    valid_i, stall_o, coord_x_i, coord_y_i,          into block
//            last_in_batch_i
//   output   valid_o, stall_i, warped_x_o, warped_y_o,        out of block
//            last_out_o
//
// One transaction is taken per cycle while stall_o is low; a result passes
// through the lane stages and then the output register, the lane depth being
// set by the bit-per-cell final divide of the rational pieces.
// Reset clears the valid bits of the pipeline and the output register.
// While a result waits under stall_i the whole cell chain holds.
// ----------------------------------------------------------------------------
module cubic_spline_filter_warp import csfw_pkg::*; #(
  parameter int IN_FRAC_BITS  = IN_FRAC_BITS_DEF,
  parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        stall_o,
  input  logic [IN_WIDTH-1:0]         coord_x_i,
  input  logic [IN_WIDTH-1:0]         coord_y_i,
  input  logic                        last_in_batch_i,
  output logic                        valid_o,
  input  logic                        stall_i,
  output logic signed [OUT_WIDTH-1:0] warped_x_o,
  output logic signed [OUT_WIDTH-1:0] warped_y_o,
  output logic                        last_out_o
);

  localparam int LAT = csfw_lane_latency(OUT_FRAC_BITS);

  logic en;
  logic vld_q  [0:LAT-1];
  logic last_q [0:LAT-1];
  logic valid_q, last_out_q;
  logic signed [OUT_WIDTH-1:0] wx, wy, wx_q, wy_q;

  // the chain moves unless a finished transaction is held
  assign en      = !(valid_q && stall_i);
  assign stall_o = !en;

  // one lane per coordinate
  csfw_lane #(.IN_FRAC_BITS(IN_FRAC_BITS), .OUT_FRAC_BITS(OUT_FRAC_BITS)) u_lane_x (
    .clk_i    (clk_i),
    .en_i     (en),
    .coord_i  (coord_x_i),
    .warped_o (wx)
  );

  csfw_lane #(.IN_FRAC_BITS(IN_FRAC_BITS), .OUT_FRAC_BITS(OUT_FRAC_BITS)) u_lane_y (
    .clk_i    (clk_i),
    .en_i     (en),
    .coord_i  (coord_y_i),
    .warped_o (wy)
  );

  // valid bits along the chain and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LAT; i++) vld_q[i] <= 1'b0;
      valid_q <= 1'b0;
    end else if (en) begin
      vld_q[0] <= valid_i;
      for (int i = 1; i < LAT; i++) vld_q[i] <= vld_q[i-1];
      valid_q <= vld_q[LAT-1];
    end
  end

  // batch flag and results travel alongside
  always_ff @(posedge clk_i) begin
    if (en) begin
      last_q[0] <= last_in_batch_i;
      for (int i = 1; i < LAT; i++) last_q[i] <= last_q[i-1];
      last_out_q <= last_q[LAT-1];
      wx_q       <= wx;
      wy_q       <= wy;
    end
  end

  assign valid_o    = valid_q;
  assign warped_x_o = wx_q;
  assign warped_y_o = wy_q;
  assign last_out_o = last_out_q;

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for cubic_spline_filter_warp: a directed table of
// boundary coordinates, then random pairs aimed at each piece of the inverse,
// checked field by field against given results or a bit-exact fixed-point predictor.
// ----------------------------------------------------------------------------
module tb_top import csfw_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IFB         = IN_FRAC_BITS_DEF;
  localparam int OFB         = OUT_FRAC_BITS_DEF;
  localparam int NUM_RANDOM  = 2000;
  localparam int DRAIN_WAIT  = 200;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic signed [OUT_WIDTH-1:0] wx;
    logic signed [OUT_WIDTH-1:0] wy;
    logic                        last;
  } warp_result_t;

  typedef struct {
    logic [IN_WIDTH-1:0]         x;
    logic [IN_WIDTH-1:0]         y;
    logic                        last;
    bit                          typed;
    logic signed [OUT_WIDTH-1:0] wx;
    logic signed [OUT_WIDTH-1:0] wy;
  } coord_row_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        valid_i;
  logic                        stall_o;
  logic [IN_WIDTH-1:0]         coord_x_i;
  logic [IN_WIDTH-1:0]         coord_y_i;
  logic                        last_in_batch_i;
  logic                        valid_o;
  logic                        stall_i;
  logic signed [OUT_WIDTH-1:0] warped_x_o;
  logic signed [OUT_WIDTH-1:0] warped_y_o;
  logic                        last_out_o;

  warp_result_t pending_warps[$];
  int           error_count;
  int           accepted_count;
  int           result_count;
  bit           quiet_phase;

  cubic_spline_filter_warp dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (valid_i),
    .stall_o         (stall_o),
    .coord_x_i       (coord_x_i),
    .coord_y_i       (coord_y_i),
    .last_in_batch_i (last_in_batch_i),
    .valid_o         (valid_o),
    .stall_i         (stall_i),
    .warped_x_o      (warped_x_o),
    .warped_y_o      (warped_y_o),
    .last_out_o      (last_out_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #4ms;
    $display("Verification failed");
    $finish;
  end

  // truncated fourth root of m / 2^IFB, with OFB fraction bits
  function automatic longint unsigned fourth_root_q(longint unsigned m);
    logic [127:0]    lim;
    logic [127:0]    sq;
    longint unsigned r;
    longint unsigned c;
    lim = 128'(m) << (4 * OFB - IFB);
    r   = 0;
    for (int b = OFB; b >= 0; b--) begin
      c  = r | (64'd1 << b);
      sq = 128'(c * c);
      if (sq * sq <= lim) r = c;
    end
    return r;
  endfunction

  // one rational refinement step on t = p / (11 s) in Q0.30
  function automatic longint unsigned rational_step(longint unsigned p,
                                                    longint unsigned s);
    longint unsigned one;
    longint unsigned t, t2, t3, t4, num, den;
    one = 64'd1 << ARG_BITS;
    t   = (p << ARG_BITS) / (11 * s);
    t2  = (t * t) >> ARG_BITS;
    t3  = (t2 * t) >> ARG_BITS;
    t4  = (t3 * t) >> ARG_BITS;
    num = 11 * t + 6 * t2 + 8 * t3 - 9 * t4;
    den = 4 * one + 12 * t + 12 * t2 - 12 * t3;
    return (num << OFB) / den;
  endfunction

  // expected warp of one coordinate
  function automatic logic signed [OUT_WIDTH-1:0] spline_warp(
      logic [IN_WIDTH-1:0] raw);
    longint unsigned s;
    longint unsigned x;
    longint          unit;
    longint          v;
    csfw_case_e      piece;
    s    = 64'd1 << IFB;
    unit = 64'd1 << OFB;
    x    = raw;
    if (x >= s) x = s - 1;
    if (24 * x < s)           piece = CASE_LOW_ROOT;
    else if (2 * x < s)       piece = CASE_LOW_RATIONAL;
    else if (24 * x < 23 * s) piece = CASE_HIGH_RATIONAL;
    else                      piece = CASE_HIGH_ROOT;
    unique case (piece)
      CASE_LOW_ROOT:      v = longint'(fourth_root_q(24 * x)) - 2 * unit;
      CASE_LOW_RATIONAL:  v = longint'(rational_step(24 * x - s, s)) - unit;
      CASE_HIGH_RATIONAL: v = unit - longint'(rational_step(23 * s - 24 * x, s));
      default:            v = 2 * unit - longint'(fourth_root_q(24 * (s - x)));
    endcase
    if (v > 2 * unit)  v = 2 * unit;
    if (v < -2 * unit) v = -2 * unit;
    return v[OUT_WIDTH-1:0];
  endfunction

  // random coordinate aimed at the pieces and their borders
  function automatic logic [IN_WIDTH-1:0] pick_coord();
    case ($urandom_range(5))
      0:       return IN_WIDTH'($urandom_range(2730));
      1:       return IN_WIDTH'($urandom_range(62806, 65535));
      2:       return IN_WIDTH'($urandom_range(2720, 2740));
      3:       return IN_WIDTH'($urandom_range(32758, 32778));
      4:       return IN_WIDTH'($urandom_range(62795, 62815));
      default: return IN_WIDTH'($urandom);
    endcase
  endfunction

  function automatic bit take_break();
    return !quiet_phase && ($urandom_range(99) < 9);
  endfunction

  // offer one transaction and hold it until taken
  task automatic offer_coords(coord_row_t row);
    warp_result_t exp_warp;
    valid_i         <= 1'b1;
    coord_x_i       <= row.x;
    coord_y_i       <= row.y;
    last_in_batch_i <= row.last;
    do @(posedge clk_i); while (stall_o);
    exp_warp.wx   = row.typed ? row.wx : spline_warp(row.x);
    exp_warp.wy   = row.typed ? row.wy : spline_warp(row.y);
    exp_warp.last = row.last;
    pending_warps.push_back(exp_warp);
    accepted_count++;
    if (take_break()) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // receiver stall, with one long hold while the sender keeps offering
  initial begin
    bit held;
    held    = 0;
    stall_i = 1'b1;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held && accepted_count >= 300) begin
        held = 1;
        stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        stall_i <= 1'b0;
      end else begin
        stall_i <= take_break();
      end
    end
  end

  // result check against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && valid_o && !stall_i) begin
      warp_result_t exp_warp;
      if (pending_warps.size() == 0) begin
        $error("result with nothing expected: x=%0d y=%0d last=%0b",
               warped_x_o, warped_y_o, last_out_o);
        error_count++;
      end else begin
        exp_warp = pending_warps.pop_front();
        result_count++;
        if (warped_x_o !== exp_warp.wx) begin
          $error("warped_x: expected %0d, got %0d", exp_warp.wx, warped_x_o);
          error_count++;
        end
        if (warped_y_o !== exp_warp.wy) begin
          $error("warped_y: expected %0d, got %0d", exp_warp.wy, warped_y_o);
          error_count++;
        end
        if (last_out_o !== exp_warp.last) begin
          $error("last_out: expected %0b, got %0b", exp_warp.last, last_out_o);
          error_count++;
        end
      end
    end
  end

  // stimulus
  initial begin
    coord_row_t directed[$];
    coord_row_t row;
    rst_ni          = 1'b0;
    valid_i         = 1'b0;
    coord_x_i       = '0;
    coord_y_i       = '0;
    last_in_batch_i = 1'b0;
    error_count     = 0;
    accepted_count  = 0;
    result_count    = 0;
    quiet_phase     = 0;

    // zero maps to -2, one half maps to exactly zero
    directed.push_back('{16'd0,     16'd0,     1'b0, 1, -17'sd32768, -17'sd32768});
    directed.push_back('{16'd32768, 16'd32768, 1'b1, 1, 17'sd0,      17'sd0});
    directed.push_back('{16'd0,     16'd32768, 1'b0, 1, -17'sd32768, 17'sd0});
    // piece borders and the extremes, checked by the predictor
    directed.push_back('{16'd1,     16'd65535, 1'b1, 0, '0, '0});
    directed.push_back('{16'd65535, 16'd1,     1'b0, 0, '0, '0});
    directed.push_back('{16'd2730,  16'd2731,  1'b0, 0, '0, '0});
    directed.push_back('{16'd2731,  16'd2730,  1'b1, 0, '0, '0});
    directed.push_back('{16'd32767, 16'd32768, 1'b0, 0, '0, '0});
    directed.push_back('{16'd62805, 16'd62806, 1'b0, 0, '0, '0});
    directed.push_back('{16'd62806, 16'd62805, 1'b1, 0, '0, '0});
    directed.push_back('{16'd16384, 16'd49152, 1'b0, 0, '0, '0});
    directed.push_back('{16'hAAAA,  16'h5555,  1'b1, 0, '0, '0});
    directed.push_back('{16'h5555,  16'hAAAA,  1'b0, 0, '0, '0});
    directed.push_back('{16'hFFFF,  16'hFFFF,  1'b1, 0, '0, '0});

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) offer_coords(directed[i]);

    // random pairs, with a quiet stretch and one full drain in the middle
    for (int n = 0; n < NUM_RANDOM; n++) begin
      quiet_phase = (n >= 800 && n < 1100);
      if (n == 1500) begin
        valid_i <= 1'b0;
        wait (pending_warps.size() == 0);
        @(posedge clk_i);
      end
      row.x     = pick_coord();
      row.y     = pick_coord();
      row.last  = $urandom_range(1);
      row.typed = 0;
      row.wx    = '0;
      row.wy    = '0;
      offer_coords(row);
    end
    valid_i <= 1'b0;

    wait (pending_warps.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    $display("covered %0d coordinate pairs over all four spline pieces,",
             accepted_count);
    $display("with %0d results checked under random and long output stalls",
             result_count);
    if (error_count == 0 && pending_warps.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
